### hw/rtl/qtl_pkg.sv
// ----------------------------------------------------------------------------
// qtl_pkg
// Shared codes, character constants and types for the quoted token lexer.
// ----------------------------------------------------------------------------
package qtl_pkg;

   localparam int LEN_BITS = 12;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_TOKEN  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_END_EMPTY = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_ESC_END   = 3'd3;
   localparam logic [2:0] ST_UNCLOSED  = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = 12'd255;

   localparam logic [2:0] CSR_IDX_MAX_LEN = 3'd0;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          text_byte;
      logic [LEN_BITS-1:0] token_length;
      logic                is_quoted;
      logic                began_with_escape;
      logic [2:0]          status;
      logic                last;
   } result_type;

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      logic [7:0] d;
      unique case (c)
         8'h61:   d = 8'h07;   // a
         8'h62:   d = 8'h08;   // b
         8'h66:   d = 8'h0C;   // f
         8'h6E:   d = 8'h0A;   // n
         8'h72:   d = 8'h0D;   // r
         8'h74:   d = 8'h09;   // t
         8'h76:   d = 8'h0B;   // v
         default: d = c;
      endcase
      return d;
   endfunction

endpackage

### hw/rtl/qtl_csr.sv
// ----------------------------------------------------------------------------
// qtl_csr
// Register port holding the token length limit.
// ----------------------------------------------------------------------------
module qtl_csr
   import qtl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output logic [LEN_BITS-1:0] max_len
);

   logic [LEN_BITS-1:0] max_len_ff;
   logic [LEN_BITS-1:0] max_len_in;
   logic                sel_max_len;

   assign csr_pready  = 1'b1;
   assign sel_max_len = ({csr_paddr[2], 2'b00} == CSR_IDX_MAX_LEN);

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_max_len) begin
         max_len_in = csr_pwdata[LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_prdata = sel_max_len ? {{(32-LEN_BITS){1'b0}}, max_len_ff} : 32'd0;
   assign max_len    = max_len_ff;

endmodule

### hw/rtl/qtl_core.sv
// ----------------------------------------------------------------------------
// qtl_core
// Lexer state and the combinational decision for one item.
// ----------------------------------------------------------------------------
module qtl_core
   import qtl_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic                     req_type,
   input  logic [7:0]               char_byte,
   input  logic [LEN_BITS-1:0]      max_len,
   output logic                     res_valid,
   output result_type               res,
   output logic [POSITION_BITS-1:0] res_start_line,
   output logic [POSITION_BITS-1:0] res_start_column,
   output logic [POSITION_BITS-1:0] res_end_line,
   output logic [POSITION_BITS-1:0] res_end_column
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic                     in_comment_ff, in_comment_in;
   logic                     escape_ff, escape_in;
   logic                     open_ff, open_in;
   logic                     quoted_ff, quoted_in;
   logic                     began_esc_ff, began_esc_in;
   logic                     done_ff, done_in;
   logic                     overflow_ff, overflow_in;
   logic [LEN_BITS-1:0]      count_ff, count_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] column_ff, column_in;
   logic [POSITION_BITS-1:0] prior_cols_ff, prior_cols_in;
   logic [POSITION_BITS-1:0] first_line_ff, first_line_in;
   logic [POSITION_BITS-1:0] first_column_ff, first_column_in;

   logic       emit_req, emit_here, app_req, open_req, open_quoted, open_esc;
   logic       stat_req, esc_set, esc_clr, comment_set, comment_clr, done_set, move;
   logic [2:0] emit_status, stat_code, fin_err;
   logic [7:0] app_val;
   logic       app_ok, adv;
   logic [POSITION_BITS-1:0] end_line, end_column;

   assign fin_err = (open_ff && quoted_ff) ? ST_UNCLOSED :
                    escape_ff              ? ST_ESC_END  : ST_OK;

   always_comb begin
      emit_req    = 1'b0;
      emit_here   = 1'b0;
      emit_status = ST_OK;
      app_req     = 1'b0;
      app_val     = char_byte;
      open_req    = 1'b0;
      open_quoted = 1'b0;
      open_esc    = 1'b0;
      stat_req    = 1'b0;
      stat_code   = ST_OK;
      esc_set     = 1'b0;
      esc_clr     = 1'b0;
      comment_set = 1'b0;
      comment_clr = 1'b0;
      done_set    = 1'b0;
      move        = 1'b0;
      if (req_type) begin
         if (done_ff) begin
            stat_req  = 1'b1;
            stat_code = ST_END_EMPTY;
         end else begin
            done_set = 1'b1;
            if (count_ff != '0) begin
               emit_req    = 1'b1;
               emit_status = fin_err;
            end else begin
               stat_req  = 1'b1;
               stat_code = (fin_err != ST_OK) ? fin_err : ST_END_EMPTY;
            end
         end
      end else if (!done_ff && !overflow_ff) begin
         move = 1'b1;
         priority if (in_comment_ff) begin
            comment_clr = (char_byte == CH_LF);
         end else if (escape_ff) begin
            app_req = 1'b1;
            app_val = decode_escape(char_byte);
            esc_clr = 1'b1;
         end else if (is_separator(char_byte)) begin
            if (open_ff) begin
               if (quoted_ff) begin
                  app_req = 1'b1;
               end else begin
                  emit_req = 1'b1;
               end
            end
         end else if (char_byte == CH_QUOTE) begin
            open_quoted = 1'b1;
            if (open_ff) begin
               if (quoted_ff) begin
                  emit_req  = 1'b1;
                  emit_here = 1'b1;
               end else begin
                  emit_req = 1'b1;
                  open_req = 1'b1;
               end
            end else begin
               open_req = 1'b1;
            end
         end else if (char_byte == CH_BSL) begin
            esc_set  = 1'b1;
            open_esc = 1'b1;
            open_req = !open_ff;
         end else if (char_byte == CH_HASH) begin
            if (open_ff && quoted_ff) begin
               app_req = 1'b1;
            end else begin
               comment_set = 1'b1;
               emit_req    = (count_ff != '0);
            end
         end else begin
            open_req = !open_ff;
            app_req  = 1'b1;
         end
      end
   end

   assign app_ok = (count_ff < max_len);
   assign adv    = move && !(app_req && !app_ok);

   // end of token: here, one back, last column of the previous line, or line 1 column 1
   always_comb begin
      priority if (emit_here) begin
         end_line   = line_ff;
         end_column = column_ff;
      end else if (column_ff != POS_ONE) begin
         end_line   = line_ff;
         end_column = column_ff - POS_ONE;
      end else if (line_ff > POS_ONE) begin
         end_line   = line_ff - POS_ONE;
         end_column = prior_cols_ff;
      end else begin
         end_line   = POS_ONE;
         end_column = POS_ONE;
      end
   end

   always_comb begin
      res              = '0;
      res_start_line   = '0;
      res_start_column = '0;
      res_end_line     = '0;
      res_end_column   = '0;
      priority if (stat_req) begin
         res.kind   = KIND_STATUS;
         res.status = stat_code;
         res.last   = 1'b1;
      end else if (emit_req) begin
         res.kind              = KIND_TOKEN;
         res.token_length      = count_ff;
         res.is_quoted         = quoted_ff;
         res.began_with_escape = began_esc_ff;
         res.status            = emit_status;
         res.last              = 1'b1;
         res_start_line        = first_line_ff;
         res_start_column      = first_column_ff;
         res_end_line          = end_line;
         res_end_column        = end_column;
      end else if (app_req && app_ok) begin
         res.kind      = KIND_BYTE;
         res.text_byte = app_val;
      end else if (app_req) begin
         res.kind   = KIND_STATUS;
         res.status = ST_TOO_LARGE;
      end else begin
         res = '0;
      end
   end

   assign res_valid = go && (stat_req || emit_req || app_req);

   always_comb begin
      in_comment_in   = in_comment_ff;
      escape_in       = escape_ff;
      open_in         = open_ff;
      quoted_in       = quoted_ff;
      began_esc_in    = began_esc_ff;
      done_in         = done_ff;
      overflow_in     = overflow_ff;
      count_in        = count_ff;
      line_in         = line_ff;
      column_in       = column_ff;
      prior_cols_in   = prior_cols_ff;
      first_line_in   = first_line_ff;
      first_column_in = first_column_ff;
      if (go) begin
         if (comment_set) in_comment_in = 1'b1;
         if (comment_clr) in_comment_in = 1'b0;
         if (esc_set) escape_in = 1'b1;
         if (esc_clr && app_ok) escape_in = 1'b0;
         if (done_set) done_in = 1'b1;
         if (app_req && !app_ok) overflow_in = 1'b1;
         if (app_req && app_ok) count_in = count_ff + LEN_BITS'(1);
         if (emit_req) begin
            count_in = '0;
            open_in  = 1'b0;
         end
         if (open_req) begin
            open_in         = 1'b1;
            quoted_in       = open_quoted;
            began_esc_in    = open_esc;
            first_line_in   = line_ff;
            first_column_in = column_ff;
         end
         if (adv) begin
            if (char_byte == CH_LF) begin
               if (line_ff != POS_MAX) line_in = line_ff + POS_ONE;
               prior_cols_in = column_ff;
               column_in     = POS_ONE;
            end else if (column_ff != POS_MAX) begin
               column_in = column_ff + POS_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff   <= 1'b0;
         escape_ff       <= 1'b0;
         open_ff         <= 1'b0;
         quoted_ff       <= 1'b0;
         began_esc_ff    <= 1'b0;
         done_ff         <= 1'b0;
         overflow_ff     <= 1'b0;
         count_ff        <= '0;
         line_ff         <= POS_ONE;
         column_ff       <= POS_ONE;
         prior_cols_ff   <= '0;
         first_line_ff   <= POS_ONE;
         first_column_ff <= POS_ONE;
      end else begin
         in_comment_ff   <= in_comment_in;
         escape_ff       <= escape_in;
         open_ff         <= open_in;
         quoted_ff       <= quoted_in;
         began_esc_ff    <= began_esc_in;
         done_ff         <= done_in;
         overflow_ff     <= overflow_in;
         count_ff        <= count_in;
         line_ff         <= line_in;
         column_ff       <= column_in;
         prior_cols_ff   <= prior_cols_in;
         first_line_ff   <= first_line_in;
         first_column_ff <= first_column_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared");
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (count_ff == '0))
      else $error("bytes counted with no open token");
   a_escape_open: assert property (@(posedge clock) disable iff (reset)
      (escape_ff && !done_ff) |-> open_ff)
      else $error("escape pending outside a token");
`endif

endmodule

### hw/rtl/quoted_token_lexer.sv
// ----------------------------------------------------------------------------
// quoted_token_lexer
// Streaming whitespace-separated tokenizer with quotes, escapes and comments.
// ----------------------------------------------------------------------------
// Input channel (req_): one item per text byte (req_type 0) or a finish item
// (req_type 1). Result channel (rsp_): decoded bytes, token-complete records
// with start/end line and column, and status items. Each input item yields
// zero or one result. The length limit is set through the csr_ port; the user
// must write it only while idle, as the block itself does not enforce this.
// An item is registered at the input, decided by the lexer core and loaded
// into the result register. Throughput: one item per cycle while rsp_stall
// does not hold a result, as the core decides each item combinationally.
// Stall: while rsp_stall holds a result, the input register keeps its item
// and req_stall rises once that register is full; nothing is lost.
// Reset (synchronous): clears all lexer state to line 1 column 1, empties
// both registers and sets the length limit to 255.
// ----------------------------------------------------------------------------
module quoted_token_lexer
   import qtl_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [7:0]               req_char_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_text_byte,
   output logic [LEN_BITS-1:0]      rsp_token_length,
   output logic [POSITION_BITS-1:0] rsp_start_line,
   output logic [POSITION_BITS-1:0] rsp_start_column,
   output logic [POSITION_BITS-1:0] rsp_end_line,
   output logic [POSITION_BITS-1:0] rsp_end_column,
   output logic                     rsp_is_quoted,
   output logic                     rsp_began_with_escape,
   output logic [2:0]               rsp_status,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_type_ff;
   logic [7:0]               in_char_ff;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_res_ff;
   logic [POSITION_BITS-1:0] out_sl_ff, out_sc_ff, out_el_ff, out_ec_ff;

   logic                     out_free, go, accept;
   logic [LEN_BITS-1:0]      max_len;
   logic                     res_valid;
   result_type               res;
   logic [POSITION_BITS-1:0] res_sl, res_sc, res_el, res_ec;

   qtl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   qtl_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .go               (go),
      .req_type         (in_type_ff),
      .char_byte        (in_char_ff),
      .max_len          (max_len),
      .res_valid        (res_valid),
      .res              (res),
      .res_start_line   (res_sl),
      .res_start_column (res_sc),
      .res_end_line     (res_el),
      .res_end_column   (res_ec)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   assign out_valid_in = out_free ? res_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff <= req_type;
         in_char_ff <= req_char_byte;
      end
      if (out_free && res_valid) begin
         out_res_ff <= res;
         out_sl_ff  <= res_sl;
         out_sc_ff  <= res_sc;
         out_el_ff  <= res_el;
         out_ec_ff  <= res_ec;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_kind              = out_res_ff.kind;
   assign rsp_text_byte         = out_res_ff.text_byte;
   assign rsp_token_length      = out_res_ff.token_length;
   assign rsp_start_line        = out_sl_ff;
   assign rsp_start_column      = out_sc_ff;
   assign rsp_end_line          = out_el_ff;
   assign rsp_end_column        = out_ec_ff;
   assign rsp_is_quoted         = out_res_ff.is_quoted;
   assign rsp_began_with_escape = out_res_ff.began_with_escape;
   assign rsp_status            = out_res_ff.status;
   assign rsp_last              = out_res_ff.last;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quoted token lexer.
// Streams text bytes through the req_ channel and shadows the lexer state to
// predict every decoded byte, token record and status item on rsp_. Phases
// at different length limits (written over csr_) are followed by a closing
// phase that overflows a token and sends finish items. Both sides idle and
// stall at random, with a long receiver hold-off and a sender pause on the way.
// ----------------------------------------------------------------------------
module tb_top
   import qtl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam logic [2:0] LIMIT_ADDR  = 3'(4 * CSR_IDX_MAX_LEN);
   localparam logic [15:0] POS_TOP    = 16'hFFFF;

   typedef struct packed {
      logic [1:0]          kind;
      logic [7:0]          text_byte;
      logic [LEN_BITS-1:0] token_length;
      logic [15:0]         start_line;
      logic [15:0]         start_column;
      logic [15:0]         end_line;
      logic [15:0]         end_column;
      logic                is_quoted;
      logic                began_with_escape;
      logic [2:0]          status;
      logic                last;
   } lexeme_type;

   class lexer_shadow_type;
      logic [LEN_BITS-1:0] limit;
      bit                  in_comment, esc_pending, tok_open, tok_quoted, tok_escaped;
      bit                  finished, overflowed;
      logic [LEN_BITS-1:0] nbytes;
      logic [15:0]         line, col, prev_cols, tok_line, tok_col;
      lexeme_type          lexemes_due[$];
      int                  errors;

      function new();
         limit     = MAX_LEN_RESET;
         nbytes    = '0;
         line      = 16'd1;
         col       = 16'd1;
         prev_cols = 16'd0;
         tok_line  = 16'd1;
         tok_col   = 16'd1;
         errors    = 0;
      endfunction

      static function bit is_gap(logic [7:0] c);
         return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      endfunction

      function bit would_append(logic [7:0] c);
         if (in_comment)
            return 1'b0;
         if (esc_pending)
            return 1'b1;
         if (is_gap(c) || (c == CH_HASH))
            return tok_open && tok_quoted;
         return (c != CH_QUOTE) && (c != CH_BSL);
      endfunction

      // swap a byte that would push the open token past the limit for one
      // that closes it
      function logic [7:0] tame(logic [7:0] c);
         bit risky;
         risky = would_append(c) || ((c == CH_BSL) && !in_comment && !esc_pending);
         if (risky && (nbytes >= limit))
            return (tok_open && tok_quoted) ? CH_QUOTE : CH_SPACE;
         return c;
      endfunction

      function logic [7:0] unescape(logic [7:0] c);
         case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: return c;
         endcase
      endfunction

      function void open_tok(bit quoted, bit escaped);
         tok_line    = line;
         tok_col     = col;
         tok_open    = 1'b1;
         tok_quoted  = quoted;
         tok_escaped = escaped;
      endfunction

      function bit grow(inout lexeme_type r, input logic [7:0] b);
         if (nbytes < limit) begin
            nbytes      = nbytes + LEN_BITS'(1);
            r.kind      = KIND_BYTE;
            r.text_byte = b;
            return 1'b1;
         end
         overflowed = 1'b1;
         r.kind     = KIND_STATUS;
         r.status   = ST_TOO_LARGE;
         return 1'b0;
      endfunction

      function void close_tok(inout lexeme_type r, input bit here, input logic [2:0] st);
         logic [15:0] el, ec;
         if (here) begin
            el = line;
            ec = col;
         end else if (col != 16'd1) begin
            el = line;
            ec = col - 16'd1;
         end else if (line > 16'd1) begin
            el = line - 16'd1;
            ec = prev_cols;
         end else begin
            el = 16'd1;
            ec = 16'd1;
         end
         r.kind              = KIND_TOKEN;
         r.token_length      = nbytes;
         r.start_line        = tok_line;
         r.start_column      = tok_col;
         r.end_line          = el;
         r.end_column        = ec;
         r.is_quoted         = tok_quoted;
         r.began_with_escape = tok_escaped;
         r.status            = st;
         r.last              = 1'b1;
         nbytes   = '0;
         tok_open = 1'b0;
      endfunction

      function void take_item(bit fin, logic [7:0] c);
         lexeme_type r;
         bit         produce;
         bit         adv;
         logic [2:0] err;
         r       = '0;
         produce = 1'b0;
         adv     = 1'b1;
         if (fin) begin
            if (finished) begin
               r.kind   = KIND_STATUS;
               r.status = ST_END_EMPTY;
               r.last   = 1'b1;
            end else begin
               err = ST_OK;
               if (esc_pending)
                  err = ST_ESC_END;
               if (tok_open && tok_quoted)
                  err = ST_UNCLOSED;
               if (nbytes != '0) begin
                  close_tok(r, 1'b0, err);
               end else begin
                  r.kind   = KIND_STATUS;
                  r.status = (err != ST_OK) ? err : ST_END_EMPTY;
                  r.last   = 1'b1;
               end
               finished = 1'b1;
            end
            lexemes_due.push_back(r);
            return;
         end
         if (finished || overflowed)
            return;

         if (in_comment) begin
            if (c == CH_LF)
               in_comment = 1'b0;
         end else if (esc_pending) begin
            produce = 1'b1;
            if (grow(r, unescape(c)))
               esc_pending = 1'b0;
            else
               adv = 1'b0;
         end else if (is_gap(c)) begin
            if (tok_open) begin
               produce = 1'b1;
               if (tok_quoted) begin
                  if (!grow(r, c))
                     adv = 1'b0;
               end else begin
                  close_tok(r, 1'b0, ST_OK);
               end
            end
         end else if (c == CH_QUOTE) begin
            if (tok_open) begin
               produce = 1'b1;
               if (tok_quoted) begin
                  close_tok(r, 1'b1, ST_OK);
               end else begin
                  close_tok(r, 1'b0, ST_OK);
                  open_tok(1'b1, 1'b0);
               end
            end else begin
               open_tok(1'b1, 1'b0);
            end
         end else if (c == CH_BSL) begin
            esc_pending = 1'b1;
            if (!tok_open)
               open_tok(1'b0, 1'b1);
         end else if (c == CH_HASH) begin
            if (tok_open && tok_quoted) begin
               produce = 1'b1;
               if (!grow(r, c))
                  adv = 1'b0;
            end else begin
               in_comment = 1'b1;
               if (nbytes != '0) begin
                  produce = 1'b1;
                  close_tok(r, 1'b0, ST_OK);
               end
            end
         end else begin
            if (!tok_open)
               open_tok(1'b0, 1'b0);
            produce = 1'b1;
            if (!grow(r, c))
               adv = 1'b0;
         end

         if (adv) begin
            if (c == CH_LF) begin
               if (line < POS_TOP)
                  line = line + 16'd1;
               prev_cols = col;
               col       = 16'd1;
            end else if (col < POS_TOP) begin
               col = col + 16'd1;
            end
         end
         if (produce)
            lexemes_due.push_back(r);
      endfunction

      function void field_cmp(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_lexeme(lexeme_type got);
         lexeme_type want;
         if (lexemes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got kind %0d byte %h",
                     $time, got.kind, got.text_byte);
            return;
         end
         want = lexemes_due.pop_front();
         field_cmp("kind", 16'(want.kind), 16'(got.kind));
         field_cmp("text_byte", 16'(want.text_byte), 16'(got.text_byte));
         field_cmp("token_length", 16'(want.token_length), 16'(got.token_length));
         field_cmp("start_line", want.start_line, got.start_line);
         field_cmp("start_column", want.start_column, got.start_column);
         field_cmp("end_line", want.end_line, got.end_line);
         field_cmp("end_column", want.end_column, got.end_column);
         field_cmp("is_quoted", 16'(want.is_quoted), 16'(got.is_quoted));
         field_cmp("began_with_escape", 16'(want.began_with_escape),
                   16'(got.began_with_escape));
         field_cmp("status", 16'(want.status), 16'(got.status));
         field_cmp("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = 1'b0;
   logic [7:0]          req_char_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_kind;
   logic [7:0]          rsp_text_byte;
   logic [LEN_BITS-1:0] rsp_token_length;
   logic [15:0]         rsp_start_line;
   logic [15:0]         rsp_start_column;
   logic [15:0]         rsp_end_line;
   logic [15:0]         rsp_end_column;
   logic                rsp_is_quoted;
   logic                rsp_began_with_escape;
   logic [2:0]          rsp_status;
   logic                rsp_last;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = 3'd0;
   logic [31:0]         csr_pwdata = 32'd0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   lexer_shadow_type shadow = new();
   lexeme_type       seen;
   bit               calm = 1'b0;
   int               hold_asked = 0;
   int               hold_seen = 0;
   int               hold_left = 0;
   int               cycle_count = 0;

   quoted_token_lexer DUT (.*);

   assign seen = {rsp_kind, rsp_text_byte, rsp_token_length, rsp_start_line,
                  rsp_start_column, rsp_end_line, rsp_end_column, rsp_is_quoted,
                  rsp_began_with_escape, rsp_status, rsp_last};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_lexeme(seen);
   end

   task automatic send(input bit fin, input logic [7:0] c);
      while (!calm && ($urandom_range(0, 99) < 21)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= fin;
      req_char_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_item(fin, c);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.lexemes_due.size() != 0) @(posedge clock);
   endtask

   task automatic read_limit();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= LIMIT_ADDR;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[LEN_BITS-1:0] !== shadow.limit) begin
         shadow.errors++;
         $display("%0t: max_token_length read, expected %0d, got %0d",
                  $time, shadow.limit, csr_prdata[LEN_BITS-1:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // bring the lexer to a clean state, let it go idle, then change the limit and read it back
   task automatic set_limit(input logic [LEN_BITS-1:0] value);
      while (shadow.in_comment || shadow.esc_pending || shadow.tok_open) begin
         if (shadow.in_comment)
            send(1'b0, CH_LF);
         else if (shadow.esc_pending)
            send(1'b0, "x");
         else if (shadow.tok_quoted)
            send(1'b0, CH_QUOTE);
         else
            send(1'b0, CH_SPACE);
      end
      drain();
      repeat (8) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= {20'd0, value};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow.limit = value;
      @(posedge clock);
      read_limit();
   endtask

   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return 8'($urandom_range(8'h61, 8'h7A));
      if (roll < 52)
         return CH_SPACE;
      if (roll < 58)
         return ($urandom_range(0, 5) == 0) ? CH_NUL : 8'($urandom_range(9, 13));
      if (roll < 66)
         return CH_LF;
      if (roll < 73)
         return CH_QUOTE;
      if (roll < 79)
         return CH_BSL;
      if (roll < 83)
         return CH_HASH;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_text(input int count);
      repeat (count) send(1'b0, shadow.tame(pick_char()));
   endtask

   // overflow one token, then finish three times with dropped bytes before and between the finish items
   task automatic overflow_and_finish();
      logic [LEN_BITS-1:0] lim;
      bit                  quoted;
      bit                  escaped;
      lim     = LEN_BITS'($urandom_range(0, 3));
      quoted  = 1'($urandom_range(0, 1));
      escaped = 1'($urandom_range(0, 1));
      set_limit(lim);
      if (quoted)
         send(1'b0, CH_QUOTE);
      repeat (lim) send(1'b0, "m");
      if (escaped)
         send(1'b0, CH_BSL);
      send(1'b0, "w");
      repeat (6) send(1'b0, 8'($urandom_range(0, 255)));
      send(1'b1, 8'($urandom_range(0, 255)));
      repeat (4) send(1'b0, 8'($urandom_range(0, 255)));
      send(1'b1, 8'($urandom_range(0, 255)));
      send(1'b1, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [7:0] opening [30] = '{"a", 8'hFF, CH_NUL, "b", CH_QUOTE, CH_SPACE, CH_HASH,
                                   CH_LF, CH_BSL, "n", CH_QUOTE, CH_BSL, "t", "x", 8'h0B,
                                   CH_HASH, "q", CH_LF, "y", CH_HASH, CH_LF, CH_BSL, CH_LF,
                                   CH_CR, 8'h0C, CH_QUOTE, CH_QUOTE, CH_TAB, 8'h80, CH_SPACE};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_limit();

      foreach (opening[i])
         send(1'b0, opening[i]);

      set_limit(12'd1);
      random_text(300);

      set_limit(12'd4095);
      random_text(250);

      set_limit(LEN_BITS'($urandom_range(2, 6)));
      calm = 1'b1;
      random_text(250);
      calm = 1'b0;

      set_limit(LEN_BITS'($urandom_range(7, 64)));
      random_text(100);
      hold_asked <= hold_asked + 1;
      random_text(150);

      set_limit(LEN_BITS'($urandom_range(1, 4095)));
      random_text(125);
      drain();
      random_text(125);

      set_limit(MAX_LEN_RESET);
      random_text(420);

      overflow_and_finish();

      drain();
      repeat (10) @(posedge clock);
      if (shadow.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
